FILE: design/acet_pkg.sv
// Shared types and constants for the box contact event tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package acet_pkg;

  localparam int LAYER_COUNT = 8;
  localparam int PAIR_SETS   = 64;
  localparam int PAIR_WAYS   = 4;

  localparam int ID_W     = 16;
  localparam int COORD_W  = 16;
  localparam int LP_W     = 6;
  localparam int LAYER_W  = 3;
  localparam int SET_BITS = $clog2(PAIR_SETS);
  localparam int WAY_BITS = $clog2(PAIR_WAYS);

  localparam logic [LAYER_W:0] LAYER_LIMIT = (LAYER_W + 1)'(LAYER_COUNT);

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ENTER = 2'd1;
  localparam logic [1:0] EV_STAY  = 2'd2;
  localparam logic [1:0] EV_EXIT  = 2'd3;

  typedef logic [2*ID_W-1:0] key_t;
  typedef logic [SET_BITS-1:0] set_idx_t;

  typedef struct packed {
    key_t key;
    logic touching;
  } way_entry_t;

  typedef way_entry_t [PAIR_WAYS-1:0] set_word_t;

  // Everything the table needs about the pair that is being looked up.
  typedef struct packed {
    key_t     key;
    set_idx_t set;
    logic     overlap;
    logic     deleting;
    logic     skip;
  } lookup_t;

  typedef struct packed {
    logic [1:0] contact_event;
    logic       overflow;
  } table_res_t;

endpackage

`default_nettype wire

FILE: design/acet_overlap.sv
// Exact integer overlap test of two axis-aligned boxes: 2*|dx| < w1+w2 on both axes.
// Depends on acet_pkg for field widths.
`default_nettype none

module acet_overlap import acet_pkg::*; (
  input  wire logic signed [COORD_W-1:0] left_x,
  input  wire logic signed [COORD_W-1:0] left_y,
  input  wire logic        [COORD_W-1:0] left_w,
  input  wire logic        [COORD_W-1:0] left_h,
  input  wire logic signed [COORD_W-1:0] right_x,
  input  wire logic signed [COORD_W-1:0] right_y,
  input  wire logic        [COORD_W-1:0] right_w,
  input  wire logic        [COORD_W-1:0] right_h,
  output logic                           overlap
);

  logic signed [COORD_W:0] dx, dy;
  logic        [COORD_W:0] adx, ady;
  logic        [COORD_W:0] sum_w, sum_h;
  logic        [COORD_W+1:0] dbl_x, dbl_y;

  always_comb begin
    dx    = (COORD_W + 1)'(left_x) - (COORD_W + 1)'(right_x);
    dy    = (COORD_W + 1)'(left_y) - (COORD_W + 1)'(right_y);
    adx   = dx[COORD_W] ? (COORD_W + 1)'(-dx) : (COORD_W + 1)'(dx);
    ady   = dy[COORD_W] ? (COORD_W + 1)'(-dy) : (COORD_W + 1)'(dy);
    sum_w = {1'b0, left_w} + {1'b0, right_w};
    sum_h = {1'b0, left_h} + {1'b0, right_h};
    dbl_x = {adx, 1'b0};
    dbl_y = {ady, 1'b0};
    overlap = (dbl_x < {1'b0, sum_w}) && (dbl_y < {1'b0, sum_h});
  end

endmodule

`default_nettype wire

FILE: design/acet_pair_table.sv
// Set-associative pair table: one set-wide synchronous memory of keys and touching bits,
// valid bits in flip-flops, and the lookup, allocate and event logic. Depends on acet_pkg.
`default_nettype none

module acet_pair_table import acet_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rd_en,
  input  wire set_idx_t   rd_set,
  input  wire logic       commit,
  input  wire lookup_t    lk,
  output table_res_t      res
);

  set_word_t mem [PAIR_SETS];
  set_word_t rdata;
  set_word_t wdata;
  logic [PAIR_WAYS-1:0] valid [PAIR_SETS];
  logic [PAIR_WAYS-1:0] set_valid;

  logic                hit_any, free_any, found;
  logic [WAY_BITS-1:0] hit_way, free_way, slot;
  logic                prev;
  logic                touching_next;
  logic                wr_en;

  // The valid bits of the set are read at the same edge as its memory word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata     <= mem[rd_set];
      set_valid <= valid[rd_set];
    end
    if (wr_en) begin
      mem[lk.set] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < PAIR_SETS; s++) begin
        valid[s] <= '0;
      end
    end else if (wr_en) begin
      valid[lk.set][slot] <= 1'b1;
    end
  end

  // Lowest matching way wins; a new pair takes the lowest free way.
  always_comb begin
    hit_any   = 1'b0;
    free_any  = 1'b0;
    hit_way   = '0;
    free_way  = '0;
    for (int w = PAIR_WAYS - 1; w >= 0; w--) begin
      if (set_valid[w] && rdata[w].key == lk.key) begin
        hit_any = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!set_valid[w]) begin
        free_any = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
    found = hit_any || free_any;
    slot  = hit_any ? hit_way : free_way;
    prev  = hit_any && rdata[hit_way].touching;

    touching_next = lk.overlap && !lk.deleting;

    res.overflow      = !lk.skip && !found;
    res.contact_event = EV_NONE;
    if (!lk.skip) begin
      if (lk.overlap) begin
        if (prev) begin
          res.contact_event = lk.deleting ? EV_EXIT : EV_STAY;
        end else if (!lk.deleting) begin
          res.contact_event = EV_ENTER;
        end
      end else if (prev) begin
        res.contact_event = EV_EXIT;
      end
    end

    wr_en = commit && !lk.skip && found;
    wdata = rdata;
    wdata[slot].key      = lk.key;
    wdata[slot].touching = touching_next;
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("pair table read and write in the same cycle");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    commit && res.overflow |-> &set_valid)
    else $error("overflow reported with a free way in the set");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> valid[$past(lk.set)][$past(slot)])
    else $error("written way not marked valid");

endmodule

`default_nettype wire

FILE: design/aabb_contact_event_tracker_unit.sv
// Box contact event tracker. Each word on the input channel is one candidate pair of boxes;
// each produces exactly one result word (enter, stay, exit or none, plus overlap and
// table-overflow flags). The overlap test and the set read of the pair table happen in the
// accept cycle, the lookup and write-back once the output register can take the result;
// the input stalls until then. The table is a 64-set, 4-way memory read and rewritten a
// whole set at a time; it is ready right after reset.
`default_nettype none

module aabb_contact_event_tracker_unit import acet_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,

  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [63:0]               cfg_data,

  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [ID_W-1:0]           left_id,
  input  wire logic [ID_W-1:0]           right_id,
  input  wire logic [LP_W-1:0]           layer_pair,
  input  wire logic signed [COORD_W-1:0] left_x,
  input  wire logic signed [COORD_W-1:0] left_y,
  input  wire logic [COORD_W-1:0]        left_w,
  input  wire logic [COORD_W-1:0]        left_h,
  input  wire logic signed [COORD_W-1:0] right_x,
  input  wire logic signed [COORD_W-1:0] right_y,
  input  wire logic [COORD_W-1:0]        right_w,
  input  wire logic [COORD_W-1:0]        right_h,
  input  wire logic                      either_deleting,

  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     contact_event,
  output logic                           boxes_overlap,
  output logic                           table_overflow
);

  logic [63:0] layer_pair_enable;
  logic        busy;
  logic        accept;
  logic        finish;
  lookup_t     lk;
  lookup_t     lk_next;
  logic        overlap_in;
  table_res_t  res;
  logic [ID_W-1:0] lo_id, hi_id;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = busy;
  assign cfg_ready = !busy;
  assign finish    = busy && (!out_valid || !out_stall);

  acet_overlap u_overlap (
    .left_x  (left_x),
    .left_y  (left_y),
    .left_w  (left_w),
    .left_h  (left_h),
    .right_x (right_x),
    .right_y (right_y),
    .right_w (right_w),
    .right_h (right_h),
    .overlap (overlap_in)
  );

  always_comb begin
    lo_id = (left_id < right_id) ? left_id : right_id;
    hi_id = (left_id < right_id) ? right_id : left_id;
    lk_next.key      = {lo_id, hi_id};
    lk_next.set      = SET_BITS'(left_id ^ right_id);
    lk_next.overlap  = overlap_in;
    lk_next.deleting = either_deleting;
    lk_next.skip     = ({1'b0, layer_pair[LP_W-1:LAYER_W]} >= LAYER_LIMIT) ||
                       ({1'b0, layer_pair[LAYER_W-1:0]} >= LAYER_LIMIT) ||
                       !layer_pair_enable[layer_pair] ||
                       (left_id == right_id);
  end

  acet_pair_table u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_set (lk_next.set),
    .commit (finish),
    .lk     (lk),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_pair_enable <= '0;
    end else if (cfg_valid && cfg_ready) begin
      layer_pair_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lk <= lk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      contact_event  <= res.contact_event;
      boxes_overlap  <= lk.overlap && !lk.skip;
      table_overflow <= res.overflow;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted word did not start a lookup");

  a_overflow_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_overflow |-> contact_event == EV_NONE || contact_event == EV_ENTER)
    else $error("overflowed pair reported a prior contact");

  a_touch_needs_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && (contact_event == EV_ENTER || contact_event == EV_STAY) |-> boxes_overlap)
    else $error("enter or stay without overlap");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking bench for the box contact event tracker: directed pair words, then random
// phases under several layer-pair masks, with a scoreboard class predicting every result.
// Depends on acet_pkg and the aabb_contact_event_tracker_unit RTL only.
`default_nettype none

module testbench;
  import acet_pkg::*;

  typedef struct {
    logic [ID_W-1:0]           lid;
    logic [ID_W-1:0]           rid;
    logic [LP_W-1:0]           lp;
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
    logic [COORD_W-1:0]        lw;
    logic [COORD_W-1:0]        lh;
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    logic [COORD_W-1:0]        rw;
    logic [COORD_W-1:0]        rh;
    logic                      del;
  } pair_word_t;

  typedef struct {
    logic [1:0] ev;
    logic       overlap;
    logic       overflow;
  } contact_t;

  localparam int TABLE_WAYS = PAIR_SETS * PAIR_WAYS;
  localparam int POOL_SIZE  = 20;

  // Tracks the pair table and the layer mask, and holds the results still owed by the block.
  class contact_ledger;
    logic [63:0]         layer_enable;
    logic [2*ID_W-1:0]   way_key [TABLE_WAYS];
    bit                  way_used [TABLE_WAYS];
    bit                  way_touching [TABLE_WAYS];
    contact_t            owed_contacts[$];
    int                  mismatches;
    int                  results_seen;
    int                  event_count [4];
    int                  overflow_count;
    int                  skip_count;

    function new();
      layer_enable = '0;
      mismatches = 0;
      results_seen = 0;
      overflow_count = 0;
      skip_count = 0;
      foreach (event_count[i]) event_count[i] = 0;
      foreach (way_used[i]) begin
        way_used[i] = 0;
        way_touching[i] = 0;
      end
    endfunction

    // Exact integer form of |c1 - c2| < (s1 + s2) / 2.
    function bit axis_hit(logic signed [COORD_W-1:0] c1, logic signed [COORD_W-1:0] c2,
                          logic [COORD_W-1:0] s1, logic [COORD_W-1:0] s2);
      int d;
      int span;
      d = int'(c1) - int'(c2);
      if (d < 0) d = -d;
      span = int'(s1) + int'(s2);
      return (2 * d) < span;
    endfunction

    function contact_t predict_contact(pair_word_t w);
      contact_t          r;
      logic [ID_W-1:0]   lo;
      logic [ID_W-1:0]   hi;
      logic [2*ID_W-1:0] key;
      int                base;
      int                hit;
      int                free_way;
      int                slot;
      bit                prev;
      r.ev = EV_NONE;
      r.overlap = 0;
      r.overflow = 0;
      if (w.lp[5:3] >= LAYER_COUNT || w.lp[2:0] >= LAYER_COUNT || !layer_enable[w.lp] ||
          w.lid == w.rid) begin
        skip_count++;
        return r;
      end
      r.overlap = axis_hit(w.lx, w.rx, w.lw, w.rw) && axis_hit(w.ly, w.ry, w.lh, w.rh);
      lo = (w.lid < w.rid) ? w.lid : w.rid;
      hi = (w.lid < w.rid) ? w.rid : w.lid;
      key = {lo, hi};
      base = int'((w.lid ^ w.rid) % PAIR_SETS) * PAIR_WAYS;
      hit = -1;
      free_way = -1;
      for (int i = 0; i < PAIR_WAYS; i++) begin
        if (way_used[base + i] && way_key[base + i] == key) begin
          if (hit < 0) hit = base + i;
        end else if (!way_used[base + i] && free_way < 0) begin
          free_way = base + i;
        end
      end
      slot = hit;
      if (slot < 0 && free_way >= 0) begin
        slot = free_way;
        way_used[slot] = 1;
        way_key[slot] = key;
        way_touching[slot] = 0;
      end
      r.overflow = (slot < 0);
      prev = (slot >= 0) ? way_touching[slot] : 0;
      if (r.overlap) begin
        if (prev) begin
          r.ev = w.del ? EV_EXIT : EV_STAY;
        end else if (!w.del) begin
          r.ev = EV_ENTER;
        end
      end else if (prev) begin
        r.ev = EV_EXIT;
      end
      if (slot >= 0) begin
        if (r.ev == EV_ENTER) way_touching[slot] = 1;
        if (r.ev == EV_EXIT) way_touching[slot] = 0;
      end
      event_count[r.ev]++;
      if (r.overflow) overflow_count++;
      return r;
    endfunction

    function void note_pair(pair_word_t w);
      owed_contacts.push_back(predict_contact(w));
    endfunction

    function void check_result(logic [1:0] ev, logic overlap, logic overflow);
      contact_t want;
      results_seen++;
      if (owed_contacts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing owed: event=%0d overlap=%0b overflow=%0b",
                   $time, ev, overlap, overflow);
        return;
      end
      want = owed_contacts.pop_front();
      if (ev !== want.ev || overlap !== want.overlap || overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d: event %0d/%0d overlap %0b/%0b overflow %0b/%0b (exp/got)",
                   $time, results_seen, want.ev, ev, want.overlap, overlap, want.overflow,
                   overflow);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [63:0]               cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [ID_W-1:0]           left_id = '0;
  logic [ID_W-1:0]           right_id = '0;
  logic [LP_W-1:0]           layer_pair = '0;
  logic signed [COORD_W-1:0] left_x = '0;
  logic signed [COORD_W-1:0] left_y = '0;
  logic [COORD_W-1:0]        left_w = '0;
  logic [COORD_W-1:0]        left_h = '0;
  logic signed [COORD_W-1:0] right_x = '0;
  logic signed [COORD_W-1:0] right_y = '0;
  logic [COORD_W-1:0]        right_w = '0;
  logic [COORD_W-1:0]        right_h = '0;
  logic                      either_deleting = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                contact_event;
  logic                      boxes_overlap;
  logic                      table_overflow;

  contact_ledger   ledger;
  bit              steady_run = 1'b0;
  bit              want_holdoff = 1'b0;
  int              holdoff_left = 0;
  int              masks_used = 0;
  int              words_sent = 0;
  logic [ID_W-1:0] id_pool [POOL_SIZE];

  aabb_contact_event_tracker_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .left_id(left_id),
    .right_id(right_id),
    .layer_pair(layer_pair),
    .left_x(left_x),
    .left_y(left_y),
    .left_w(left_w),
    .left_h(left_h),
    .right_x(right_x),
    .right_y(right_y),
    .right_w(right_w),
    .right_h(right_h),
    .either_deleting(either_deleting),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .contact_event(contact_event),
    .boxes_overlap(boxes_overlap),
    .table_overflow(table_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off on request so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) ledger.check_result(contact_event, boxes_overlap,
                                                       table_overflow);
      if (want_holdoff) begin
        holdoff_left = 150;
        want_holdoff = 1'b0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady_run && ($urandom_range(0, 99) < 20);
      end
    end
  end

  function automatic pair_word_t box_word(int lid, int rid, int lp, int lx, int ly, int lw,
                                          int lh, int rx, int ry, int rw, int rh, bit del);
    pair_word_t w;
    w.lid = ID_W'(lid);
    w.rid = ID_W'(rid);
    w.lp  = LP_W'(lp);
    w.lx  = COORD_W'(lx);
    w.ly  = COORD_W'(ly);
    w.lw  = COORD_W'(lw);
    w.lh  = COORD_W'(lh);
    w.rx  = COORD_W'(rx);
    w.ry  = COORD_W'(ry);
    w.rw  = COORD_W'(rw);
    w.rh  = COORD_W'(rh);
    w.del = del;
    return w;
  endfunction

  // Mostly pairs from a small id pool so the same keys come back, the rest fresh ids; most
  // boxes lie near each other so that enter, stay and exit all happen, the rest anywhere.
  function automatic pair_word_t random_word(int fresh_pct);
    pair_word_t w;
    if ($urandom_range(0, 99) < fresh_pct) begin
      w.lid = ID_W'($urandom);
      w.rid = ID_W'($urandom);
    end else begin
      w.lid = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      w.rid = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    w.lp = LP_W'($urandom_range(0, 63));
    w.lx = COORD_W'($urandom);
    w.ly = COORD_W'($urandom);
    if ($urandom_range(0, 99) < 70) begin
      w.lw = COORD_W'($urandom_range(0, 800));
      w.lh = COORD_W'($urandom_range(0, 800));
      w.rw = COORD_W'($urandom_range(0, 800));
      w.rh = COORD_W'($urandom_range(0, 800));
      w.rx = w.lx + COORD_W'($urandom_range(0, 1000)) - COORD_W'(500);
      w.ry = w.ly + COORD_W'($urandom_range(0, 1000)) - COORD_W'(500);
    end else begin
      w.lw = COORD_W'($urandom);
      w.lh = COORD_W'($urandom);
      w.rw = COORD_W'($urandom);
      w.rh = COORD_W'($urandom);
      w.rx = COORD_W'($urandom);
      w.ry = COORD_W'($urandom);
    end
    w.del = ($urandom_range(0, 99) < 15);
    return w;
  endfunction

  function automatic logic [63:0] mirror_layers(logic [63:0] m);
    logic [63:0] s;
    for (int a = 0; a < 8; a++)
      for (int b = 0; b < 8; b++)
        s[a*8+b] = m[a*8+b] | m[b*8+a];
    return s;
  endfunction

  task automatic send_pair(input pair_word_t w);
    while (!steady_run && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    left_id         <= w.lid;
    right_id        <= w.rid;
    layer_pair      <= w.lp;
    left_x          <= w.lx;
    left_y          <= w.ly;
    left_w          <= w.lw;
    left_h          <= w.lh;
    right_x         <= w.rx;
    right_y         <= w.ry;
    right_w         <= w.rw;
    right_h         <= w.rh;
    either_deleting <= w.del;
    do @(posedge clk); while (in_stall);
    ledger.note_pair(w);
    words_sent++;
  endtask

  // The mask may only change with nothing in flight, so drain and let the pipe settle first.
  task automatic write_layer_enable(input logic [63:0] mask);
    while (ledger.owed_contacts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mask;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ledger.layer_enable = mask;
    masks_used++;
  endtask

  task automatic run_random(input int count, input int fresh_pct);
    for (int i = 0; i < count; i++) send_pair(random_word(fresh_pct));
    in_valid <= 1'b0;
  endtask

  task automatic run_directed();
    // With the mask still at its reset value every pair is skipped.
    send_pair(box_word(1, 2, 0, 0, 0, 10, 10, 4, 4, 10, 10, 0));
    in_valid <= 1'b0;
    write_layer_enable('1);
    // One pair walked through every transition.
    send_pair(box_word(1, 2, 0, 0, 0, 10, 10, 4, 4, 10, 10, 0));
    send_pair(box_word(2, 1, 9, 0, 0, 10, 10, 4, 4, 10, 10, 0));
    send_pair(box_word(1, 2, 9, 0, 0, 10, 10, 4, 4, 10, 10, 1));
    send_pair(box_word(1, 2, 9, 0, 0, 10, 10, 4, 4, 10, 10, 1));
    send_pair(box_word(1, 2, 9, 0, 0, 10, 10, 4, 4, 10, 10, 0));
    send_pair(box_word(1, 2, 9, 0, 0, 10, 10, 400, 4, 10, 10, 0));
    send_pair(box_word(1, 2, 9, 0, 0, 10, 10, 400, 4, 10, 10, 0));
    send_pair(box_word(7, 7, 18, 0, 0, 10, 10, 0, 0, 10, 10, 0));
    // Coordinate and size extremes; distance exactly equal to the half-sum does not touch.
    send_pair(box_word(16'h0000, 16'hFFFF, 63, -32768, 0, 65535, 1, 32767, 0, 65535, 1, 0));
    send_pair(box_word(16'hFFFF, 16'h0000, 63, -32767, 0, 65535, 1, 32767, 0, 65535, 1, 0));
    send_pair(box_word(16'hFFFF, 16'h0000, 63, 0, -32768, 5, 65535, 5, 32767, 5, 65535, 0));
    send_pair(box_word(3, 4, 27, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Five keys in the same set: the fifth finds it full and is never stored.
    for (int n = 1; n <= 5; n++)
      send_pair(box_word(n * 64, n * 64 + 5, 36, 100, 100, 20, 20, 105, 95, 20, 20, 0));
    send_pair(box_word(5 * 64, 5 * 64 + 5, 36, 100, 100, 20, 20, 105, 95, 20, 20, 0));
    send_pair(box_word(5 * 64, 5 * 64 + 5, 36, 100, 100, 2, 2, 900, 95, 2, 2, 0));
    send_pair(box_word(64, 69, 36, 100, 100, 2, 2, 900, 95, 2, 2, 0));
    in_valid <= 1'b0;
    write_layer_enable('0);
    send_pair(box_word(64, 69, 45, 100, 100, 20, 20, 105, 95, 20, 20, 0));
    send_pair(box_word(1, 2, 0, 0, 0, 10, 10, 4, 4, 10, 10, 1));
    in_valid <= 1'b0;
  endtask

  initial begin
    ledger = new();
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    write_layer_enable('1);
    steady_run = 1'b1;
    run_random(300, 0);
    steady_run = 1'b0;
    run_random(300, 5);

    write_layer_enable(mirror_layers({$urandom, $urandom}));
    run_random(400, 20);

    write_layer_enable(mirror_layers(64'hA5A5_5A5A_0F0F_F0F0));
    run_random(350, 10);

    write_layer_enable('1);
    want_holdoff = 1'b1;
    run_random(500, 30);

    while (ledger.owed_contacts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d pair words under %0d layer masks; %0d skipped, %0d set-full cases.",
             words_sent, masks_used, ledger.skip_count, ledger.overflow_count);
    $display("Events seen: none %0d, enter %0d, stay %0d, exit %0d; %0d mismatches.",
             ledger.event_count[EV_NONE], ledger.event_count[EV_ENTER],
             ledger.event_count[EV_STAY], ledger.event_count[EV_EXIT], ledger.mismatches);
    if (ledger.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Run timed out.");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
